@@ rtl/robin_hood_two_choice_hash_table_macros.svh @@
// Assertion macros for the RTL
`ifndef ROBIN_HOOD_TWO_CHOICE_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_TWO_CHOICE_HASH_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RHTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RHTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rhtc_pkg.sv @@
package rhtc_pkg;

  // default parameters
  localparam int TABLE_SIZE_DEF = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int DIST_W = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = 8'd255;

  // commands
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_INS_ABS = 2'd1;
  localparam logic [1:0] CMD_FIND    = 2'd2;
  localparam logic [1:0] CMD_REMOVE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // one finished result item
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [8:0]  entry_count;
    logic [7:0]  max_probe;
  } result_t;

endpackage

@@ rtl/rhtc_ram.sv @@
module rhtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rhtc_engine.sv @@
`include "robin_hood_two_choice_hash_table_macros.svh"

module rhtc_engine #(
  parameter int TABLE_SIZE = rhtc_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = rhtc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = rhtc_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_hash,
  input  logic [31:0]        in_key,
  input  logic [31:0]        in_value,
  output logic               done_valid,
  input  logic               done_ready,
  output rhtc_pkg::result_t  done_res
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int DW    = rhtc_pkg::DIST_W;
  localparam int ENT_W = DW + VALUE_BITS + KEY_BITS + 32;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_LKH   = 4'd2;
  localparam logic [3:0] S_LKL   = 4'd3;
  localparam logic [3:0] S_LKX   = 4'd4;
  localparam logic [3:0] S_SRCH  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PCMP  = 4'd7;
  localparam logic [3:0] S_SHR   = 4'd8;
  localparam logic [3:0] S_SHC   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            cmd_r, cmd_nxt;
  logic [31:0]           hash_r, hash_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [31:0]           c_hash_r, c_hash_nxt;
  logic [KEY_BITS-1:0]   c_key_r, c_key_nxt;
  logic [VALUE_BITS-1:0] c_val_r, c_val_nxt;
  logic [DW-1:0]         c_dist_r, c_dist_nxt;
  logic [IDX_W-1:0]      hs_r, hs_nxt, ls_r, ls_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt, hole_r, hole_nxt;
  logic [DW-1:0]         n_r, n_nxt;
  logic [IDX_W-1:0]      sn_r, sn_nxt;
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DW-1:0]         plim_r, plim_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [31:0]           vout_r, vout_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [ENT_W-1:0]      wr_data, rd_data;

  logic [31:0]           r_hash;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_val;
  logic [DW-1:0]         r_dist;
  logic [15:0]           hh16;
  logic [IDX_W-1:0]      home_hi, home_lo;
  logic                  full, r_match;
  logic [DW-1:0]         d_keep, d_inc;

  // entry RAM: {distance, value, key, hash}
  rhtc_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SIZE)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign {r_dist, r_val, r_key, r_hash} = rd_data;

  // home slots and shared compare
  assign hh16    = hash_r[31:16] ^ hash_r[15:0];
  assign home_hi = IDX_W'(hh16);
  assign home_lo = IDX_W'(hash_r[31:16]);
  assign full    = (cnt_r == CNT_W'(TABLE_SIZE));
  assign r_match = (r_hash == hash_r) && (r_key == key_r);

  // distance after a place step: swap picks resident distance, then saturating +1
  assign d_keep = (c_dist_r > r_dist) ? r_dist : c_dist_r;
  assign d_inc  = (d_keep < rhtc_pkg::DIST_MAX) ? d_keep + 1'b1 : d_keep;

  assign in_ready   = (state_r == S_IDLE);
  assign done_valid = (state_r == S_DONE);
  assign done_res   = '{status: status_r, value_out: vout_r,
                        entry_count: 9'(cnt_r), max_probe: plim_r};

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    hash_nxt   = hash_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    c_hash_nxt = c_hash_r;
    c_key_nxt  = c_key_r;
    c_val_nxt  = c_val_r;
    c_dist_nxt = c_dist_r;
    hs_nxt     = hs_r;
    ls_nxt     = ls_r;
    pos_nxt    = pos_r;
    hole_nxt   = hole_r;
    n_nxt      = n_r;
    sn_nxt     = sn_r;
    valid_nxt  = valid_r;
    cnt_nxt    = cnt_r;
    plim_nxt   = plim_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = {c_dist_r, c_val_r, c_key_r, c_hash_r};
    rd_addr    = pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          hash_nxt   = in_hash;
          key_nxt    = KEY_BITS'(in_key);
          val_nxt    = VALUE_BITS'(in_value);
          status_nxt = rhtc_pkg::ST_OK;
          vout_nxt   = '0;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        hs_nxt = home_hi;
        ls_nxt = home_lo;
        n_nxt  = '0;
        if (cmd_r == rhtc_pkg::CMD_INSERT) begin
          if (full) begin
            status_nxt = rhtc_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SRCH;
          end
        end else begin
          state_nxt = S_LKH;
        end
      end
      // lookup: high slot read, then low slot read, per step
      S_LKH: begin
        rd_addr   = hs_r;
        state_nxt = S_LKL;
      end
      S_LKL: begin
        rd_addr = ls_r;
        if (valid_r[hs_r] && r_match) begin
          hole_nxt  = hs_r;
          vout_nxt  = 32'(r_val);
          state_nxt = S_LKX;
          n_nxt     = DW'(1);
          sn_nxt    = '0;
        end else begin
          state_nxt = S_LKX;
          n_nxt     = n_r;
          sn_nxt    = IDX_W'(1);
        end
      end
      S_LKX: begin
        // sn_r flags "high slot did not match"
        priority if (sn_r == '0 || (valid_r[ls_r] && r_match)) begin
          if (sn_r != '0) begin
            hole_nxt = ls_r;
            vout_nxt = 32'(r_val);
          end
          n_nxt = '0;
          sn_nxt = '0;
          unique case (cmd_r)
            rhtc_pkg::CMD_INS_ABS: begin
              status_nxt = rhtc_pkg::ST_DUP;
              state_nxt  = S_DONE;
            end
            rhtc_pkg::CMD_REMOVE: begin
              vout_nxt = '0;
              valid_nxt[(sn_r != '0) ? ls_r : hs_r] = 1'b0;
              pos_nxt  = ((sn_r != '0) ? ls_r : hs_r) + 1'b1;
              cnt_nxt  = cnt_r - 1'b1;
              state_nxt = S_SHR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (n_r == plim_r) begin
          sn_nxt = '0;
          if (cmd_r == rhtc_pkg::CMD_INS_ABS) begin
            if (full) begin
              status_nxt = rhtc_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              hs_nxt    = home_hi;
              ls_nxt    = home_lo;
              state_nxt = S_SRCH;
            end
          end else begin
            status_nxt = rhtc_pkg::ST_NF;
            state_nxt  = S_DONE;
          end
        end else begin
          n_nxt     = n_r + 1'b1;
          hs_nxt    = hs_r + 1'b1;
          ls_nxt    = ls_r + 1'b1;
          state_nxt = S_LKH;
        end
      end
      // pick the home slot that reaches a free entry first
      S_SRCH: begin
        c_hash_nxt = hash_r;
        c_key_nxt  = key_r;
        c_val_nxt  = val_r;
        c_dist_nxt = '0;
        priority if (!valid_r[hs_r]) begin
          pos_nxt   = home_hi;
          state_nxt = S_PRD;
        end else if (!valid_r[ls_r]) begin
          pos_nxt   = home_lo;
          state_nxt = S_PRD;
        end else begin
          hs_nxt = hs_r + 1'b1;
          ls_nxt = ls_r + 1'b1;
        end
      end
      S_PRD: begin
        rd_addr = pos_r;
        if (!valid_r[pos_r]) begin
          wr_en            = 1'b1;
          valid_nxt[pos_r] = 1'b1;
          cnt_nxt          = cnt_r + 1'b1;
          state_nxt        = S_DONE;
        end else begin
          state_nxt = S_PCMP;
        end
      end
      // Robin Hood swap with a richer resident
      S_PCMP: begin
        if (c_dist_r > r_dist) begin
          wr_en      = 1'b1;
          c_hash_nxt = r_hash;
          c_key_nxt  = r_key;
          c_val_nxt  = r_val;
        end
        c_dist_nxt = d_inc;
        if (d_inc > plim_r) begin
          plim_nxt = d_inc;
        end
        pos_nxt   = pos_r + 1'b1;
        state_nxt = S_PRD;
      end
      // backward shift after remove
      S_SHR: begin
        rd_addr = pos_r;
        if (sn_r == IDX_W'(TABLE_SIZE - 1) || !valid_r[pos_r]) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHC;
        end
      end
      S_SHC: begin
        if (r_dist == '0) begin
          state_nxt = S_DONE;
        end else begin
          wr_en             = 1'b1;
          wr_addr           = hole_r;
          wr_data           = {r_dist - 1'b1, r_val, r_key, r_hash};
          valid_nxt[hole_r] = 1'b1;
          valid_nxt[pos_r]  = 1'b0;
          hole_nxt          = pos_r;
          pos_nxt           = pos_r + 1'b1;
          sn_nxt            = sn_r + 1'b1;
          state_nxt         = S_SHR;
        end
      end
      S_DONE: begin
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      cnt_r   <= '0;
      plim_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      plim_r  <= plim_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    hash_r   <= hash_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    c_hash_r <= c_hash_nxt;
    c_key_r  <= c_key_nxt;
    c_val_r  <= c_val_nxt;
    c_dist_r <= c_dist_nxt;
    hs_r     <= hs_nxt;
    ls_r     <= ls_nxt;
    pos_r    <= pos_nxt;
    hole_r   <= hole_nxt;
    n_r      <= n_nxt;
    sn_r     <= sn_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
  end

  `RHTC_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_ready, "ready while busy")
  `RHTC_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(TABLE_SIZE), "count overflow")
  `RHTC_ASSERT_IMPL(a_wr_state, clk, rst_n, wr_en, state_r == S_PRD || state_r == S_PCMP || state_r == S_SHC, "stray write")
  `RHTC_ASSERT_NEXT(a_accept_start, clk, rst_n, in_valid && in_ready, state_r == S_START, "accept lost")

endmodule

@@ rtl/robin_hood_two_choice_hash_table.sv @@
// Operation: a start state and a done state wrap the walk; lookup reads the high slot,
//   then the low slot, then checks, per probe step over up to max_probe + 1 steps; insert
//   takes a search step per home pair, a read and a compare per occupied slot passed and a
//   write; remove adds a read and a check per shifted entry. All is serial on one RAM port.
// Throughput: one item at a time; the next item is taken in the cycle after a result is
//   handed to the output register, which holds it while the consumer stalls.
// Reset: synchronous active-low rst_n clears all valid bits, counts and the output valid.
module robin_hood_two_choice_hash_table #(
  parameter int TABLE_SIZE = rhtc_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = rhtc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = rhtc_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // hash_value[31:0], key[63:32], value_in[95:64]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // value_out[31:0], entry_count[40:32], max_probe[48:41]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic              done_valid, done_ready;
  rhtc_pkg::result_t done_res;
  rhtc_pkg::result_t out_r;
  logic              out_valid_r;

  rhtc_engine #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_hash    (in_tdata[31:0]),
    .in_key     (in_tdata[63:32]),
    .in_value   (in_tdata[95:64]),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_res   (done_res)
  );

  // output register
  assign done_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_ready) begin
      out_valid_r <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      out_r <= done_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {7'd0, out_r.max_probe, out_r.entry_count, out_r.value_out};

endmodule
